/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/etavg_pkg.sv */
`timescale 1ns / 1ps
package etavg_pkg;

    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;
    localparam int TRIG_W  = 16;
    localparam int THR_W   = 16;
    localparam int HOLD_W  = 24;
    localparam int PRE_W   = 5;
    localparam int POST_W  = 6;
    localparam int CFG_DW  = 24;
    localparam int CFG_IW  = 2;
    localparam int SINCE_W = 25;
    localparam int SUM_W   = 32;

    localparam logic [LEN_W-1:0] POST_LIMIT = 7'd32;

    typedef enum logic [CFG_IW-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLDOFF   = 2'd1,
        REG_PRE       = 2'd2,
        REG_POST      = 2'd3
    } t_cfg_idx;

    // one finished window waiting to be walked
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] start;
    } t_job;

    // sample ring command from the front end
    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [POS_W-1:0] addr;
    } t_ring_cmd;

endpackage

/* sv/etavg_in_if.sv */
`timescale 1ns / 1ps
interface etavg_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                               valid;
    logic                               ready;
    logic signed [SAMPLE_WIDTH-1:0]     sample;
    logic signed [etavg_pkg::TRIG_W-1:0] trigger_level;
    logic                               clear;

    modport source (output valid, sample, trigger_level, clear, input ready);
    modport sink   (input valid, sample, trigger_level, clear, output ready);
endinterface

/* sv/etavg_out_if.sv */
`timescale 1ns / 1ps
interface etavg_out_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) ();
    logic                              valid;
    logic                              ready;
    logic [etavg_pkg::POS_W-1:0]       position;
    logic signed [SAMPLE_WIDTH-1:0]    average;
    logic [COUNT_WIDTH-1:0]            events;
    logic                              last;

    modport source (output valid, position, average, events, last, input ready);
    modport sink   (input valid, position, average, events, last, output ready);
endinterface

/* sv/etavg_front.sv */
`timescale 1ns / 1ps
module etavg_front #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  etavg_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [etavg_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    input  logic signed [etavg_pkg::TRIG_W-1:0] i_trigger_level,
    input  logic                               i_clear,
    input  logic                               i_back_busy,
    input  logic                               i_q_empty,
    output logic                               o_push,
    output etavg_pkg::t_job                    o_job,
    output etavg_pkg::t_ring_cmd               o_ring,
    output logic signed [SAMPLE_WIDTH-1:0]     o_ring_data,
    output logic [COUNT_WIDTH-1:0]             o_count
);
    import etavg_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [LEN_W-1:0]       DEPTH_L   = LEN_W'(WINDOW_DEPTH);
    localparam logic [LEN_W-1:0]       PRE_CAP   = LEN_W'(WINDOW_DEPTH - 2);
    localparam logic [AW-1:0]          HEAD_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SINCE_W-1:0]     SINCE_MAX = '1;

    logic signed [THR_W-1:0] r_threshold;
    logic [HOLD_W-1:0]       r_holdoff;
    logic [PRE_W-1:0]        r_pre;
    logic [POST_W-1:0]       r_post;

    logic [AW-1:0]          r_head,   n_head;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic                   r_active, n_active;
    logic [POST_W-1:0]      r_tat,    n_tat;
    logic [SINCE_W-1:0]     r_since,  n_since;

    logic              accept;
    logic [LEN_W-1:0]  pre_l, pre_eff, post_l, post_c, room, post_eff, len;
    logic [AW-1:0]     head_inc;
    logic [LEN_W-1:0]  head_l, start_l;
    logic [SINCE_W-1:0] since_inc;
    logic [POST_W-1:0] tat_inc;
    logic              trig_hit;

    assign o_ready = !i_back_busy && i_q_empty;
    assign accept  = i_valid && o_ready;
    assign o_count = r_count;
    assign o_ring_data = i_sample;

    // window size as it stands on this tick
    always_comb begin
        pre_l   = LEN_W'(r_pre);
        pre_eff = (pre_l > PRE_CAP) ? PRE_CAP : pre_l;
        post_l  = LEN_W'(r_post);
        if (post_l == '0) begin
            post_c = LEN_W'(1);
        end else if (post_l > POST_LIMIT) begin
            post_c = POST_LIMIT;
        end else begin
            post_c = post_l;
        end
        room     = DEPTH_L - LEN_W'(1) - pre_eff;
        post_eff = (post_c > room) ? room : post_c;
        len      = pre_eff + post_eff + LEN_W'(1);
    end

    always_comb begin
        head_inc  = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
        head_l    = LEN_W'(head_inc);
        start_l   = (head_l >= len) ? head_l - len : head_l + DEPTH_L - len;
        since_inc = (r_since == SINCE_MAX) ? r_since : r_since + SINCE_W'(1);
        tat_inc   = r_tat + POST_W'(1);
        trig_hit  = (i_trigger_level >= r_threshold)
                 && (since_inc > SINCE_W'(r_holdoff))
                 && (r_count != COUNT_MAX);
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_active = r_active;
        n_tat    = r_tat;
        n_since  = r_since;
        o_push   = 1'b0;
        o_ring.wr   = 1'b0;
        o_ring.clr  = 1'b0;
        o_ring.addr = POS_W'(r_head);
        o_job.len   = len;
        o_job.start = POS_W'(start_l);
        if (accept) begin
            n_since = since_inc;
            if (i_clear) begin
                n_count    = '0;
                n_active   = 1'b0;
                n_tat      = '0;
                o_ring.clr = 1'b1;
            end else begin
                o_ring.wr = 1'b1;
                n_head    = head_inc;
                if (r_active) begin
                    n_tat = tat_inc;
                    if (LEN_W'(tat_inc) == post_eff) begin
                        o_push = 1'b1;
                    end else if (LEN_W'(tat_inc) > post_eff) begin
                        // tick after the window was emitted closes it
                        n_tat    = '0;
                        n_active = 1'b0;
                    end
                end else if (trig_hit) begin
                    n_since  = '0;
                    n_active = 1'b1;
                    n_tat    = '0;
                    n_count  = r_count + COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'sd16384;
            r_holdoff   <= 24'd5000;
            r_pre       <= 5'd31;
            r_post      <= 6'd32;
            r_head      <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_tat       <= '0;
            r_since     <= SINCE_MAX;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_active <= n_active;
            r_tat    <= n_tat;
            r_since  <= n_since;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    REG_HOLDOFF:   r_holdoff   <= i_cfg_data[HOLD_W-1:0];
                    REG_PRE:       r_pre       <= i_cfg_data[PRE_W-1:0];
                    REG_POST:      r_post      <= i_cfg_data[POST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* sv/etavg_queue.sv */
`timescale 1ns / 1ps
module etavg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  etavg_pkg::t_job i_job,
    input  logic            i_pop,
    output etavg_pkg::t_job o_job,
    output logic            o_empty
);
    import etavg_pkg::*;

    localparam int QD = 2;

    t_job       r_slot [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_job   = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

/* sv/etavg_back.sv */
`timescale 1ns / 1ps
module etavg_back #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  etavg_pkg::t_ring_cmd            i_ring,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_ring_data,
    input  logic [COUNT_WIDTH-1:0]          i_count,
    input  logic                            i_q_empty,
    input  etavg_pkg::t_job                 i_job,
    output logic                            o_pop,
    output logic                            o_busy,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [etavg_pkg::POS_W-1:0]     o_position,
    output logic signed [SAMPLE_WIDTH-1:0]  o_average,
    output logic [COUNT_WIDTH-1:0]          o_events,
    output logic                            o_last
);
    import etavg_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int KW = $clog2(SAMPLE_WIDTH);
    localparam logic [AW-1:0]           IDX_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [KW-1:0]           K_LAST   = KW'(SAMPLE_WIDTH - 1);
    localparam logic [SAMPLE_WIDTH-1:0] AMAX     = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] HALF     = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_back_state;

    t_back_state r_state, n_state;

    // sample ring and per-position sums
    logic signed [SAMPLE_WIDTH-1:0] r_ring_mem [WINDOW_DEPTH];
    logic signed [SUM_W-1:0]        r_sum_mem  [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]        r_ring_vld;
    logic [WINDOW_DEPTH-1:0]        r_sum_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_ring_q;
    logic signed [SUM_W-1:0]        r_sum_q;
    logic                           r_ring_qv, r_sum_qv;

    logic [LEN_W-1:0]        r_len;
    logic [AW-1:0]           r_ridx;
    logic [POS_W-1:0]        r_pos;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_neg, r_over, r_zero;
    logic [COUNT_WIDTH-1:0]  r_rem;
    logic [SAMPLE_WIDTH-1:0] r_dq;
    logic [KW-1:0]           r_k;
    logic                    r_ovalid;

    logic                        pos_last, fin_load;
    logic [AW-1:0]               pos_a;
    logic signed [SUM_W:0]       add_wide;
    logic signed [SUM_W-1:0]     add_sat;
    logic [SUM_W-1:0]            mag;
    logic [SUM_W-1:0]            mag_hi;
    logic [COUNT_WIDTH:0]        trial, trial_sub;
    logic                        trial_ge;
    logic [SAMPLE_WIDTH-1:0]     avg;

    assign pos_a    = r_pos[AW-1:0];
    assign pos_last = (LEN_W'(r_pos) == r_len - LEN_W'(1));
    assign fin_load = (r_state == ST_FIN) && (!r_ovalid || i_ready);
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_ovalid;

    always_comb begin
        add_wide = {{1{r_sum_qv && r_sum_q[SUM_W-1]}}, (r_sum_qv ? r_sum_q : '0)}
                 + (r_ring_qv ? (SUM_W+1)'(r_ring_q) : '0);
        if (add_wide[SUM_W] != add_wide[SUM_W-1]) begin
            add_sat = add_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            add_sat = add_wide[SUM_W-1:0];
        end
        mag       = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
        mag_hi    = mag >> SAMPLE_WIDTH;
        trial     = {r_rem, r_dq[SAMPLE_WIDTH-1]};
        trial_sub = trial - {1'b0, i_count};
        trial_ge  = (trial >= {1'b0, i_count});
        // truncated quotient magnitude, clamped to the signed sample range
        if (r_zero) begin
            avg = '0;
        end else if (r_over) begin
            avg = r_neg ? HALF : AMAX;
        end else if (!r_neg) begin
            avg = (r_dq > AMAX) ? AMAX : r_dq;
        end else begin
            avg = (r_dq > HALF) ? HALF : SAMPLE_WIDTH'(-r_dq);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_READ;
            ST_READ: n_state = ST_ADD;
            ST_ADD:  n_state = ST_PREP;
            ST_PREP: begin
                if (i_count == '0 || mag_hi >= SUM_W'(i_count)) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:  if (r_k == K_LAST) n_state = ST_FIN;
            ST_FIN:  begin
                if (fin_load) begin
                    n_state = pos_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // valid bits stand in for clearing the stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ring.clr) begin
            r_ring_vld <= '0;
            r_sum_vld  <= '0;
        end else begin
            if (i_ring.wr) begin
                r_ring_vld[i_ring.addr[AW-1:0]] <= 1'b1;
            end
            if (r_state == ST_ADD) begin
                r_sum_vld[pos_a] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ring.wr) begin
            r_ring_mem[i_ring.addr[AW-1:0]] <= i_ring_data;
        end
        if (r_state == ST_ADD) begin
            r_sum_mem[pos_a] <= add_sat;
        end
        r_ring_q  <= r_ring_mem[r_ridx];
        r_ring_qv <= r_ring_vld[r_ridx];
        r_sum_q   <= r_sum_mem[pos_a];
        r_sum_qv  <= r_sum_vld[pos_a];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_len  <= i_job.len;
                r_ridx <= i_job.start[AW-1:0];
                r_pos  <= '0;
            end
            ST_ADD: begin
                r_sum <= add_sat;
            end
            ST_PREP: begin
                r_neg  <= r_sum[SUM_W-1];
                r_zero <= (i_count == '0);
                r_over <= (mag_hi >= SUM_W'(i_count));
                r_rem  <= mag_hi[COUNT_WIDTH-1:0];
                r_dq   <= mag[SAMPLE_WIDTH-1:0];
                r_k    <= '0;
            end
            ST_DIV: begin
                // one quotient bit per cycle
                r_rem <= trial_ge ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
                r_dq  <= {r_dq[SAMPLE_WIDTH-2:0], trial_ge};
                r_k   <= r_k + KW'(1);
            end
            ST_FIN: begin
                if (fin_load) begin
                    r_pos  <= r_pos + POS_W'(1);
                    r_ridx <= (r_ridx == IDX_LAST) ? '0 : r_ridx + AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            o_position <= r_pos;
            o_average  <= avg;
            o_events   <= i_count;
            o_last     <= pos_last;
        end
    end

endmodule

/* sv/event_triggered_average.sv */
`timescale 1ns / 1ps
// event-triggered average over a sliding sample ring
// i_item: one transaction per tick (sample, trigger_level, clear); o_res: one
// transaction per window position (position, average, events, last).
// configuration: i_cfg_we with i_cfg_idx selecting threshold, holdoff_ticks,
// pre_window or post_window, data in i_cfg_data; write only while idle.
// an ordinary tick is taken whenever ready is high. the tick that completes a
// window queues a job; the window walker reads ring and sum per position, adds,
// then runs a serial divider giving one quotient bit per cycle, skipping the
// divider when the count is zero or the quotient saturates. no tick is taken
// while the walker is busy or a job is queued.
// a stalled receiver holds the walker on the current position.
// reset loads the register defaults, empties ring and sums through valid
// bits, and needs no clearing pass; a clear transaction does the same to the
// ring, sums, event count and window state.
module event_triggered_average #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [etavg_pkg::CFG_IW-1:0]        i_cfg_idx,
    input  logic [etavg_pkg::CFG_DW-1:0]        i_cfg_data,
    etavg_in_if.sink                            i_item,
    etavg_out_if.source                         o_res
);
    import etavg_pkg::*;
    `include "assert_macros.svh"

    logic                           q_push, q_pop, q_empty, back_busy, accept;
    t_job                           job_in, job_out;
    t_ring_cmd                      ring_cmd;
    logic signed [SAMPLE_WIDTH-1:0] ring_data;
    logic [COUNT_WIDTH-1:0]         count;

    assign accept = i_item.valid && i_item.ready;

    etavg_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_item.valid),
        .o_ready         (i_item.ready),
        .i_sample        (i_item.sample),
        .i_trigger_level (i_item.trigger_level),
        .i_clear         (i_item.clear),
        .i_back_busy     (back_busy),
        .i_q_empty       (q_empty),
        .o_push          (q_push),
        .o_job           (job_in),
        .o_ring          (ring_cmd),
        .o_ring_data     (ring_data),
        .o_count         (count)
    );

    etavg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    etavg_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ring      (ring_cmd),
        .i_ring_data (ring_data),
        .i_count     (count),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_pop       (q_pop),
        .o_busy      (back_busy),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_position  (o_res.position),
        .o_average   (o_res.average),
        .o_events    (o_res.events),
        .o_last      (o_res.last)
    );

    `ASSERT_IMP(a_no_tick_while_walking, i_clk, i_rst_n, back_busy, !i_item.ready)
    `ASSERT_IMP(a_push_into_empty, i_clk, i_rst_n, q_push, q_empty)
    `ASSERT_NXT(a_job_picked_up, i_clk, i_rst_n, q_push, q_pop)
    `ASSERT_NXT(a_clear_zeroes_count, i_clk, i_rst_n, accept && i_item.clear, count == '0)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import etavg_pkg::*;

    localparam int SMP_W       = 16;
    localparam int CNT_W       = 16;
    localparam int DEPTH       = 64;
    localparam int IDLE_PCT    = 31;
    localparam int LONG_STALL  = 400;
    localparam int DRAIN_GAP   = 32;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASES      = 6;
    localparam int PHASE_TICKS = 20;
    localparam int PRESS_PHASE = 2;
    localparam int CALM_PHASE  = 4;
    localparam int PREDICTED   = -1;
    localparam int MAX_PRINTS  = 50;

    typedef enum {ROW_TICK, ROW_SETUP} t_row_kind;

    typedef struct {
        logic [POS_W-1:0]        pos;
        logic signed [SMP_W-1:0] avg;
        logic [CNT_W-1:0]        ev;
        logic                    last;
    } t_avg_res;

    typedef struct {
        t_row_kind               kind;
        logic signed [SMP_W-1:0] smp;
        logic signed [TRIG_W-1:0] trg;
        logic                    clr;
        int                      n_typed;
        logic signed [SMP_W-1:0] avg_first;
        logic signed [SMP_W-1:0] avg_second;
        logic [CNT_W-1:0]        ev;
        logic signed [THR_W-1:0] thr;
        logic [HOLD_W-1:0]       hold;
        logic [PRE_W-1:0]        pre;
        logic [POST_W-1:0]       post;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_idx;
    logic [CFG_DW-1:0]   i_cfg_data;

    etavg_in_if  #(.SAMPLE_WIDTH(SMP_W))                      item_if ();
    etavg_out_if #(.SAMPLE_WIDTH(SMP_W), .COUNT_WIDTH(CNT_W)) res_if ();

    event_triggered_average #(
        .WINDOW_DEPTH(DEPTH),
        .SAMPLE_WIDTH(SMP_W),
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if.sink),
        .o_res      (res_if.source)
    );

    // settings as last written
    logic signed [THR_W-1:0] thr_reg;
    logic [HOLD_W-1:0]       hold_reg;
    logic [PRE_W-1:0]        pre_reg;
    logic [POST_W-1:0]       post_reg;

    // averager state
    logic signed [SMP_W-1:0] ring_m [DEPTH];
    logic [POS_W-1:0]        head_m;
    logic signed [SUM_W-1:0] sums_m [DEPTH];
    logic [CNT_W-1:0]        ev_cnt;
    logic                    win_on;
    logic [POS_W-1:0]        ticks_after;
    logic [SINCE_W-1:0]      since_evt;

    t_avg_res avg_q [$];
    int       mismatches  = 0;
    bit       calm        = 1'b0;
    int       stall_asked = 0;
    int       stall_given = 0;
    int       stall_left  = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic void reset_averager();
        thr_reg  = 16'sd16384;
        hold_reg = 24'd5000;
        pre_reg  = 5'd31;
        post_reg = 6'd32;
        foreach (ring_m[i]) begin
            ring_m[i] = '0;
            sums_m[i] = '0;
        end
        head_m      = '0;
        ev_cnt      = '0;
        win_on      = 1'b0;
        ticks_after = '0;
        since_evt   = '1;
    endfunction

    // one accepted tick; window averages go to avg_q when keep is set
    function automatic void step_model(input logic signed [SMP_W-1:0] smp,
                                       input logic signed [TRIG_W-1:0] trg,
                                       input logic clr, input bit keep);
        int       pre_e;
        int       post_e;
        int       len;
        int       idx;
        longint   s;
        longint   a;
        t_avg_res r;
        if (since_evt != '1)
            since_evt++;
        if (clr) begin
            foreach (ring_m[i]) begin
                ring_m[i] = '0;
                sums_m[i] = '0;
            end
            ev_cnt      = '0;
            win_on      = 1'b0;
            ticks_after = '0;
            return;
        end
        pre_e  = (pre_reg > DEPTH - 2) ? DEPTH - 2 : int'(pre_reg);
        post_e = int'(post_reg);
        if (post_e < 1)
            post_e = 1;
        if (post_e > 32)
            post_e = 32;
        if (post_e > DEPTH - 1 - pre_e)
            post_e = DEPTH - 1 - pre_e;
        len = pre_e + post_e + 1;
        ring_m[head_m] = smp;
        head_m++;
        if (win_on) begin
            ticks_after++;
            if (int'(ticks_after) == post_e) begin
                for (int i = 0; i < len; i++) begin
                    idx = (int'(head_m) + DEPTH - len + i) % DEPTH;
                    s = longint'(sums_m[i]) + longint'(ring_m[idx]);
                    if (s > 64'sd2147483647)
                        s = 64'sd2147483647;
                    if (s < -64'sd2147483648)
                        s = -64'sd2147483648;
                    sums_m[i] = s[SUM_W-1:0];
                    a = (ev_cnt != 0) ? s / longint'(ev_cnt) : 64'sd0;
                    if (a > 64'sd32767)
                        a = 64'sd32767;
                    if (a < -64'sd32768)
                        a = -64'sd32768;
                    r.pos  = i[POS_W-1:0];
                    r.avg  = a[SMP_W-1:0];
                    r.ev   = ev_cnt;
                    r.last = (i == len - 1);
                    if (keep)
                        avg_q = {avg_q, r};
                end
            end else if (int'(ticks_after) > post_e) begin
                ticks_after = '0;
                win_on      = 1'b0;
            end
        end else if (trg >= thr_reg && since_evt > hold_reg && ev_cnt != '1) begin
            since_evt   = '0;
            win_on      = 1'b1;
            ticks_after = '0;
            ev_cnt++;
        end
    endfunction

    function automatic t_stim_row tick_row(input logic signed [SMP_W-1:0] smp,
                                           input logic signed [TRIG_W-1:0] trg,
                                           input logic clr, input int n_typed,
                                           input logic signed [SMP_W-1:0] a0 = '0,
                                           input logic signed [SMP_W-1:0] a1 = '0,
                                           input logic [CNT_W-1:0] ev = '0);
        t_stim_row r;
        r            = '{kind: ROW_TICK, default: '0};
        r.smp        = smp;
        r.trg        = trg;
        r.clr        = clr;
        r.n_typed    = n_typed;
        r.avg_first  = a0;
        r.avg_second = a1;
        r.ev         = ev;
        return r;
    endfunction

    function automatic t_stim_row setup_row(input logic signed [THR_W-1:0] thr,
                                            input logic [HOLD_W-1:0] hold,
                                            input logic [PRE_W-1:0] pre,
                                            input logic [POST_W-1:0] post);
        t_stim_row r;
        r      = '{kind: ROW_SETUP, default: '0};
        r.thr  = thr;
        r.hold = hold;
        r.pre  = pre;
        r.post = post;
        return r;
    endfunction

    task automatic send_tick(input logic signed [SMP_W-1:0] smp,
                             input logic signed [TRIG_W-1:0] trg, input logic clr);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.sample        <= smp;
        item_if.trigger_level <= trg;
        item_if.clear         <= clr;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    // registers change only once the walker has gone quiet
    task automatic configure(input logic signed [THR_W-1:0] thr, input logic [HOLD_W-1:0] hold,
                             input logic [PRE_W-1:0] pre, input logic [POST_W-1:0] post);
        item_if.valid <= 1'b0;
        while (avg_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_THRESHOLD;
        i_cfg_data <= {8'd0, thr};
        @(posedge i_clk);
        i_cfg_idx  <= REG_HOLDOFF;
        i_cfg_data <= hold;
        @(posedge i_clk);
        i_cfg_idx  <= REG_PRE;
        i_cfg_data <= {19'd0, pre};
        @(posedge i_clk);
        i_cfg_idx  <= REG_POST;
        i_cfg_data <= {18'd0, post};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr_reg  = thr;
        hold_reg = hold;
        pre_reg  = pre;
        post_reg = post;
    endtask

    always @(posedge i_clk) begin
        if (stall_given != stall_asked) begin
            stall_given   <= stall_asked;
            stall_left    <= LONG_STALL;
            res_if.ready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_averages
        t_avg_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (avg_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction pos %0d avg %0d",
                                          res_if.position, res_if.average));
            end else begin
                want = avg_q.pop_front();
                if (res_if.position !== want.pos || res_if.average !== want.avg ||
                    res_if.events !== want.ev || res_if.last !== want.last)
                    report_mismatch($sformatf(
                        "got pos %0d avg %0d ev %0d last %0b, want %0d %0d %0d %0b",
                        res_if.position, res_if.average, res_if.events, res_if.last,
                        want.pos, want.avg, want.ev, want.last));
            end
        end
    end

    initial begin : stimulus
        t_stim_row               plan [$];
        t_stim_row               r;
        logic signed [THR_W-1:0] thr;
        logic [HOLD_W-1:0]       hold;
        logic [PRE_W-1:0]        pre;
        logic [POST_W-1:0]       post;
        logic signed [SMP_W-1:0] smp;
        logic signed [TRIG_W-1:0] trg;
        logic                    clr;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = REG_THRESHOLD;
        i_cfg_data            = '0;
        item_if.valid         = 1'b0;
        item_if.sample        = '0;
        item_if.trigger_level = '0;
        item_if.clear         = 1'b0;
        res_if.ready          = 1'b0;
        reset_averager();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: threshold just missed, then hit with holdoff long expired
        plan = {plan, tick_row(16'sh7FFF, 16'sd16383, 1'b0, 0)};
        plan = {plan, tick_row(16'sh8000, 16'sd16384, 1'b0, 0)};
        plan = {plan, tick_row(16'sd0, 16'sd0, 1'b1, 0)};
        // two-sample windows at the extremes, average truncated toward zero
        plan = {plan, setup_row(16'sh8000, 24'd0, 5'd0, 6'd1)};
        plan = {plan, tick_row(16'sh8000, 16'sh8000, 1'b0, 0)};
        plan = {plan, tick_row(16'sh7FFF, 16'sd0, 1'b0, 2, 16'sh8000, 16'sh7FFF, 16'd1)};
        plan = {plan, tick_row(16'sd5, 16'sh7FFF, 1'b0, 0)};
        plan = {plan, tick_row(16'sd100, 16'sh8000, 1'b0, 0)};
        plan = {plan, tick_row(-16'sd100, 16'sd0, 1'b0, 2, -16'sd16334, 16'sd16333, 16'd2)};
        plan = {plan, tick_row(16'sd0, 16'sd0, 1'b0, 0)};
        // post of zero behaves as one
        plan = {plan, setup_row(16'sh7FFF, 24'd0, 5'd3, 6'd0)};
        plan = {plan, tick_row(16'sd1, 16'sd32766, 1'b0, 0)};
        plan = {plan, tick_row(16'sd2, 16'sh7FFF, 1'b0, 0)};
        plan = {plan, tick_row(16'sd3, 16'sd0, 1'b0, PREDICTED)};
        plan = {plan, tick_row(16'sd4, 16'sd0, 1'b0, 0)};
        // longest holdoff blocks the trigger
        plan = {plan, setup_row(16'sd0, 24'hFFFFFF, 5'd31, 6'd1)};
        plan = {plan, tick_row(-16'sd1, 16'sh7FFF, 1'b0, 0)};
        plan = {plan, setup_row(16'sd0, 24'd0, 5'd31, 6'd1)};
        plan = {plan, tick_row(16'sd7, 16'sd0, 1'b0, 0)};
        plan = {plan, tick_row(-16'sd7, 16'sd0, 1'b0, PREDICTED)};
        plan = {plan, tick_row(16'sd0, 16'sd0, 1'b1, 0)};
        plan = {plan, tick_row(16'sd9, 16'sh7FFF, 1'b0, 0)};
        // clear in the middle of an open window
        plan = {plan, tick_row(-16'sd9, 16'sd0, 1'b1, 0)};

        foreach (plan[k]) begin
            r = plan[k];
            if (r.kind == ROW_SETUP) begin
                configure(r.thr, r.hold, r.pre, r.post);
            end else begin
                send_tick(r.smp, r.trg, r.clr);
                step_model(r.smp, r.trg, r.clr, r.n_typed == PREDICTED);
                if (r.n_typed == 2) begin
                    avg_q = {avg_q, t_avg_res'{pos: 6'd0, avg: r.avg_first, ev: r.ev,
                                                last: 1'b0}};
                    avg_q = {avg_q, t_avg_res'{pos: 6'd1, avg: r.avg_second, ev: r.ev,
                                                last: 1'b1}};
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       thr = 16'sh8000;
                1:       thr = 16'sh7FFF;
                default: thr = 16'(int'($urandom_range(0, 16384)) - 8192);
            endcase
            case ($urandom_range(0, 7))
                0:       hold = 24'hFFFFFF;
                1:       hold = 24'($urandom_range(7, 60));
                default: hold = 24'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       pre = 5'd31;
                1:       pre = 5'd0;
                default: pre = 5'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       post = 6'd63;
                1:       post = 6'd0;
                2:       post = 6'd32;
                default: post = 6'($urandom_range(1, 6));
            endcase
            if (ph == PRESS_PHASE) begin
                thr  = 16'sh8000;
                hold = 24'd0;
                pre  = 5'd2;
                post = 6'd2;
            end
            configure(thr, hold, pre, post);
            if (ph == PRESS_PHASE)
                stall_asked++;
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                smp = 16'($urandom);
                if ($urandom_range(0, 1))
                    trg = 16'(int'(thr_reg) + int'($urandom_range(0, 32767 - int'(thr_reg))));
                else
                    trg = 16'($urandom);
                clr = ($urandom_range(0, 24) == 0);
                send_tick(smp, trg, clr);
                step_model(smp, trg, clr, 1'b1);
            end
            calm = 1'b0;
        end

        item_if.valid <= 1'b0;
        while (avg_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/etavg_pkg.sv
sv/etavg_in_if.sv
sv/etavg_out_if.sv
sv/etavg_front.sv
sv/etavg_queue.sv
sv/etavg_back.sv
sv/event_triggered_average.sv
bench/tb_top.sv
